[sv/sac_pkg.sv]
// -----------------------------------------------------------------------------
// sac_pkg - shared types and constants for the suffix automaton cover counter
// Command codes, datapath micro-operations and the control/status bundles
// that pass between the sequencer and the datapath.
// -----------------------------------------------------------------------------
package sac_pkg;

  // default sizing
  localparam int MAX_REF_LEN_DEF = 1024;
  localparam int MAX_STATES_DEF  = 2048;
  localparam int ALPHABET_DEF    = 26;

  // saturating piece counter width, fixed by the result format
  localparam int COUNT_W = 16;

  // automaton root state index, zero means no state
  localparam int ROOT_STATE = 1;

  // request command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // datapath micro-operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE         = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR        = 5'd1;
  localparam logic [OP_W-1:0] OP_SET_FULL     = 5'd2;
  localparam logic [OP_W-1:0] OP_APPEND_START = 5'd3;
  localparam logic [OP_W-1:0] OP_LEN_NP       = 5'd4;
  localparam logic [OP_W-1:0] OP_ROW_CLR      = 5'd5;
  localparam logic [OP_W-1:0] OP_W1_RD        = 5'd6;
  localparam logic [OP_W-1:0] OP_LINK_NP_ROOT = 5'd7;
  localparam logic [OP_W-1:0] OP_W1_SET       = 5'd8;
  localparam logic [OP_W-1:0] OP_W1_HIT       = 5'd9;
  localparam logic [OP_W-1:0] OP_LINK_NP_Q    = 5'd10;
  localparam logic [OP_W-1:0] OP_CLONE        = 5'd11;
  localparam logic [OP_W-1:0] OP_LINK_NQ      = 5'd12;
  localparam logic [OP_W-1:0] OP_LINK_Q       = 5'd13;
  localparam logic [OP_W-1:0] OP_LINK_NP_NQ   = 5'd14;
  localparam logic [OP_W-1:0] OP_CPY_RD       = 5'd15;
  localparam logic [OP_W-1:0] OP_CPY_WR       = 5'd16;
  localparam logic [OP_W-1:0] OP_W2_RD        = 5'd17;
  localparam logic [OP_W-1:0] OP_W2_SET       = 5'd18;
  localparam logic [OP_W-1:0] OP_Q_START      = 5'd19;
  localparam logic [OP_W-1:0] OP_Q_RD_WALK    = 5'd20;
  localparam logic [OP_W-1:0] OP_Q_TAKE       = 5'd21;
  localparam logic [OP_W-1:0] OP_Q_ROOT       = 5'd22;
  localparam logic [OP_W-1:0] OP_Q_FAIL       = 5'd23;
  localparam logic [OP_W-1:0] OP_Q_OUT        = 5'd24;

  // sequencer to datapath
  typedef struct packed {
    logic            take;  // capture the incoming request
    logic [OP_W-1:0] op;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic [1:0] in_command;
    logic       in_sym_ok;
    logic       full_cond;
    logic       p_zero;
    logic       t_zero;
    logic       t_eq_q;
    logic       len_match;
    logic       k_last;
    logic       failed;
    logic       walk_root;
    logic       sym_ok;
    logic       last;
    logic       out_free;
  } status_t;

endpackage

[sv/sac_ctrl.sv]
// -----------------------------------------------------------------------------
// sac_ctrl - sequencer for the suffix automaton cover counter
// Steps appends through row clear, suffix link walks, cloning and row copy,
// and query symbols through the transition lookups.
// -----------------------------------------------------------------------------
module sac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sac_pkg::status_t  status,
  output sac_pkg::ctrl_t    ctrl
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_A_LEN = 5'd1;
  localparam logic [4:0] S_A_CLR = 5'd2;
  localparam logic [4:0] S_W1_RD = 5'd3;
  localparam logic [4:0] S_W1_EV = 5'd4;
  localparam logic [4:0] S_CMP   = 5'd5;
  localparam logic [4:0] S_CL1   = 5'd6;
  localparam logic [4:0] S_CL2   = 5'd7;
  localparam logic [4:0] S_CL3   = 5'd8;
  localparam logic [4:0] S_CPR   = 5'd9;
  localparam logic [4:0] S_CPW   = 5'd10;
  localparam logic [4:0] S_W2_RD = 5'd11;
  localparam logic [4:0] S_W2_EV = 5'd12;
  localparam logic [4:0] S_Q0    = 5'd13;
  localparam logic [4:0] S_Q1    = 5'd14;
  localparam logic [4:0] S_Q2    = 5'd15;
  localparam logic [4:0] S_QFIN  = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // next state and micro-operation
  always_comb begin
    state_next = state;
    ctrl.take  = 1'b0;
    ctrl.op    = sac_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctrl.take = 1'b1;
          case (status.in_command)
            sac_pkg::CMD_CLEAR: ctrl.op = sac_pkg::OP_CLEAR;
            sac_pkg::CMD_APPEND: begin
              if (status.in_sym_ok && status.full_cond) begin
                ctrl.op = sac_pkg::OP_SET_FULL;
              end else if (status.in_sym_ok) begin
                ctrl.op    = sac_pkg::OP_APPEND_START;
                state_next = S_A_LEN;
              end
            end
            sac_pkg::CMD_QUERY: begin
              ctrl.op    = sac_pkg::OP_Q_START;
              state_next = S_Q0;
            end
            default: ctrl.op = sac_pkg::OP_NONE;
          endcase
        end
      end
      S_A_LEN: begin
        ctrl.op    = sac_pkg::OP_LEN_NP;
        state_next = S_A_CLR;
      end
      S_A_CLR: begin
        ctrl.op = sac_pkg::OP_ROW_CLR;
        if (status.k_last) begin
          state_next = S_W1_RD;
        end
      end
      // first walk: point missing edges at the new state
      S_W1_RD: begin
        if (status.p_zero) begin
          ctrl.op    = sac_pkg::OP_LINK_NP_ROOT;
          state_next = S_IDLE;
        end else begin
          ctrl.op    = sac_pkg::OP_W1_RD;
          state_next = S_W1_EV;
        end
      end
      S_W1_EV: begin
        if (status.t_zero) begin
          ctrl.op    = sac_pkg::OP_W1_SET;
          state_next = S_W1_RD;
        end else begin
          ctrl.op    = sac_pkg::OP_W1_HIT;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (status.len_match) begin
          ctrl.op    = sac_pkg::OP_LINK_NP_Q;
          state_next = S_IDLE;
        end else begin
          ctrl.op    = sac_pkg::OP_CLONE;
          state_next = S_CL1;
        end
      end
      S_CL1: begin
        ctrl.op    = sac_pkg::OP_LINK_NQ;
        state_next = S_CL2;
      end
      S_CL2: begin
        ctrl.op    = sac_pkg::OP_LINK_Q;
        state_next = S_CL3;
      end
      S_CL3: begin
        ctrl.op    = sac_pkg::OP_LINK_NP_NQ;
        state_next = S_CPR;
      end
      // clone row copy, each entry read in S_CPR and written in S_CPW
      S_CPR: begin
        ctrl.op    = sac_pkg::OP_CPY_RD;
        state_next = S_CPW;
      end
      S_CPW: begin
        ctrl.op    = sac_pkg::OP_CPY_WR;
        state_next = status.k_last ? S_W2_RD : S_CPR;
      end
      // second walk: redirect edges to the clone
      S_W2_RD: begin
        if (status.p_zero) begin
          state_next = S_IDLE;
        end else begin
          ctrl.op    = sac_pkg::OP_W2_RD;
          state_next = S_W2_EV;
        end
      end
      S_W2_EV: begin
        if (status.t_eq_q) begin
          ctrl.op    = sac_pkg::OP_W2_SET;
          state_next = S_W2_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      // query symbol
      S_Q0: begin
        if (status.failed) begin
          state_next = S_QFIN;
        end else if (status.sym_ok && !status.walk_root) begin
          ctrl.op    = sac_pkg::OP_Q_RD_WALK;
          state_next = S_Q1;
        end else begin
          ctrl.op    = sac_pkg::OP_Q_ROOT;
          state_next = S_Q2;
        end
      end
      S_Q1: begin
        if (!status.t_zero) begin
          ctrl.op    = sac_pkg::OP_Q_TAKE;
          state_next = S_QFIN;
        end else begin
          ctrl.op    = sac_pkg::OP_Q_ROOT;
          state_next = S_Q2;
        end
      end
      S_Q2: begin
        ctrl.op    = (status.sym_ok && !status.t_zero) ? sac_pkg::OP_Q_TAKE
                                                       : sac_pkg::OP_Q_FAIL;
        state_next = S_QFIN;
      end
      S_QFIN: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          ctrl.op    = sac_pkg::OP_Q_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/sac_dp.sv]
// -----------------------------------------------------------------------------
// sac_dp - datapath for the suffix automaton cover counter
// Holds the transition, suffix link and length memories, the build and walk
// registers and the result register, and carries out one micro-op a cycle.
// -----------------------------------------------------------------------------
module sac_dp #(
  parameter int MAX_REF_LEN = sac_pkg::MAX_REF_LEN_DEF,
  parameter int MAX_STATES  = sac_pkg::MAX_STATES_DEF,
  parameter int ALPHABET    = sac_pkg::ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sac_pkg::ctrl_t    ctrl,
  input  logic [1:0]        in_command,
  input  logic [4:0]        in_symbol,
  input  logic              in_last,
  output sac_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [17:0]       out_data
);

  localparam int ST_W    = $clog2(MAX_STATES);
  localparam int SYM_W   = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int LEN_W   = $clog2(MAX_REF_LEN + 1);
  localparam int T_AW    = ST_W + SYM_W;
  localparam int T_DEPTH = MAX_STATES << SYM_W;
  localparam int CW      = sac_pkg::COUNT_W;
  localparam logic [ST_W-1:0] ROOT = ST_W'(sac_pkg::ROOT_STATE);

  // memories
  logic [ST_W-1:0]  trans_mem [T_DEPTH];
  logic [ST_W-1:0]  link_mem  [MAX_STATES];
  logic [LEN_W-1:0] len_mem   [MAX_STATES];

  // control state
  logic [ST_W-1:0]        newest;
  logic [ST_W-1:0]        sc;
  logic [LEN_W-1:0]       ref_len;
  logic                   full;
  logic [ST_W-1:0]        walk;
  logic [CW-1:0]          pieces;
  logic                   failed;
  logic                   qopen;
  logic [(1<<SYM_W)-1:0]  root_valid;

  // payload registers
  logic [SYM_W-1:0] sym;
  logic             sym_ok;
  logic             last;
  logic [ST_W-1:0]  p;
  logic [ST_W-1:0]  np;
  logic [ST_W-1:0]  q;
  logic [ST_W-1:0]  nq;
  logic [LEN_W-1:0] len_p;
  logic [SYM_W-1:0] k;

  // memory read data
  logic [ST_W-1:0]  t_q;
  logic             t_bad;
  logic [ST_W-1:0]  t_rd;
  logic [ST_W-1:0]  l_q;
  logic             l_root;
  logic [ST_W-1:0]  l_rd;
  logic [LEN_W-1:0] n_q;
  logic             n_root;
  logic [LEN_W-1:0] n_rd;

  // memory ports
  logic             t_we;
  logic [T_AW-1:0]  t_waddr;
  logic [ST_W-1:0]  t_wdata;
  logic             t_re;
  logic [T_AW-1:0]  t_raddr;
  logic             l_we;
  logic [ST_W-1:0]  l_waddr;
  logic [ST_W-1:0]  l_wdata;
  logic             l_re;
  logic [ST_W-1:0]  l_raddr;
  logic             n_we;
  logic [ST_W-1:0]  n_waddr;
  logic [LEN_W-1:0] n_wdata;
  logic             n_re;
  logic [ST_W-1:0]  n_raddr;

  logic [31:0]      in_sym32;
  logic [SYM_W-1:0] in_sym;
  logic [ST_W-1:0]  sc_inc;
  logic [LEN_W-1:0] len_p_inc;
  logic             out_free;

  assign in_sym32  = 32'(in_symbol);
  assign in_sym    = in_sym32[SYM_W-1:0];
  assign sc_inc    = sc + 1'b1;
  assign len_p_inc = len_p + 1'b1;
  assign out_free  = !out_valid || out_ready;

  // unwritten root row entries read as no transition
  assign t_rd = t_bad ? '0 : t_q;

  // the root has length zero and no suffix link
  assign l_rd = l_root ? '0 : l_q;
  assign n_rd = n_root ? '0 : n_q;

  // status to the sequencer
  assign status.in_command = in_command;
  assign status.in_sym_ok  = (in_sym32 < 32'(ALPHABET));
  assign status.full_cond  = (32'(ref_len) >= 32'(MAX_REF_LEN)) ||
                             (32'(sc) + 32'd2 > 32'(MAX_STATES - 1));
  assign status.p_zero     = (p == '0);
  assign status.t_zero     = (t_rd == '0);
  assign status.t_eq_q     = (t_rd == q);
  assign status.len_match  = (len_p_inc == n_rd);
  assign status.k_last     = (32'(k) == 32'(ALPHABET - 1));
  assign status.failed     = failed;
  assign status.walk_root  = (walk == ROOT);
  assign status.sym_ok     = sym_ok;
  assign status.last       = last;
  assign status.out_free   = out_free;

  // memory port selection per micro-op
  always_comb begin
    t_we    = 1'b0;
    t_waddr = {p, sym};
    t_wdata = np;
    t_re    = 1'b0;
    t_raddr = {p, sym};
    l_we    = 1'b0;
    l_waddr = np;
    l_wdata = q;
    l_re    = 1'b0;
    l_raddr = p;
    n_we    = 1'b0;
    n_waddr = np;
    n_wdata = LEN_W'(n_rd + 1'b1);
    n_re    = 1'b0;
    n_raddr = p;
    case (ctrl.op)
      sac_pkg::OP_APPEND_START: begin
        n_re    = 1'b1;
        n_raddr = newest;
      end
      sac_pkg::OP_LEN_NP: n_we = 1'b1;
      sac_pkg::OP_ROW_CLR: begin
        t_we    = 1'b1;
        t_waddr = {np, k};
        t_wdata = '0;
      end
      sac_pkg::OP_W1_RD, sac_pkg::OP_W2_RD: begin
        t_re = 1'b1;
        l_re = 1'b1;
        n_re = 1'b1;
      end
      sac_pkg::OP_LINK_NP_ROOT: begin
        l_we    = 1'b1;
        l_wdata = ROOT;
      end
      sac_pkg::OP_W1_SET: t_we = 1'b1;
      sac_pkg::OP_W1_HIT: begin
        n_re    = 1'b1;
        n_raddr = t_rd;
      end
      sac_pkg::OP_LINK_NP_Q: l_we = 1'b1;
      sac_pkg::OP_CLONE: begin
        n_we    = 1'b1;
        n_waddr = sc_inc;
        n_wdata = len_p_inc;
        l_re    = 1'b1;
        l_raddr = q;
      end
      sac_pkg::OP_LINK_NQ: begin
        l_we    = 1'b1;
        l_waddr = nq;
        l_wdata = l_rd;
      end
      sac_pkg::OP_LINK_Q: begin
        l_we    = 1'b1;
        l_waddr = q;
        l_wdata = nq;
      end
      sac_pkg::OP_LINK_NP_NQ: begin
        l_we    = 1'b1;
        l_wdata = nq;
      end
      sac_pkg::OP_CPY_RD: begin
        t_re    = 1'b1;
        t_raddr = {q, k};
      end
      sac_pkg::OP_CPY_WR: begin
        t_we    = 1'b1;
        t_waddr = {nq, k};
        t_wdata = t_rd;
      end
      sac_pkg::OP_W2_SET: begin
        t_we    = 1'b1;
        t_wdata = nq;
      end
      sac_pkg::OP_Q_RD_WALK: begin
        t_re    = 1'b1;
        t_raddr = {walk, sym};
      end
      sac_pkg::OP_Q_ROOT: begin
        t_re    = 1'b1;
        t_raddr = {ROOT, sym};
      end
      default: t_we = 1'b0;
    endcase
  end

  // transition memory
  always_ff @(posedge clk) begin
    if (t_we) begin
      trans_mem[t_waddr] <= t_wdata;
    end
    if (t_re) begin
      t_q   <= trans_mem[t_raddr];
      t_bad <= (t_raddr[T_AW-1:SYM_W] == ROOT) && !root_valid[t_raddr[SYM_W-1:0]];
    end
  end

  // suffix link memory
  always_ff @(posedge clk) begin
    if (l_we) begin
      link_mem[l_waddr] <= l_wdata;
    end
    if (l_re) begin
      l_q    <= link_mem[l_raddr];
      l_root <= (l_raddr == ROOT);
    end
  end

  // state length memory
  always_ff @(posedge clk) begin
    if (n_we) begin
      len_mem[n_waddr] <= n_wdata;
    end
    if (n_re) begin
      n_q    <= len_mem[n_raddr];
      n_root <= (n_raddr == ROOT);
    end
  end

  // automaton and query control state, also cleared by the clear request
  always_ff @(posedge clk) begin
    if (rst || ctrl.op == sac_pkg::OP_CLEAR) begin
      newest     <= ROOT;
      sc         <= ROOT;
      ref_len    <= '0;
      full       <= 1'b0;
      walk       <= ROOT;
      pieces     <= '0;
      failed     <= 1'b0;
      qopen      <= 1'b0;
      root_valid <= '0;
    end else begin
      if (t_we && t_waddr[T_AW-1:SYM_W] == ROOT) begin
        root_valid[t_waddr[SYM_W-1:0]] <= 1'b1;
      end
      case (ctrl.op)
        sac_pkg::OP_SET_FULL: full <= 1'b1;
        sac_pkg::OP_APPEND_START: begin
          ref_len <= ref_len + 1'b1;
          sc      <= sc_inc;
          newest  <= sc_inc;
        end
        sac_pkg::OP_CLONE: sc <= sc_inc;
        sac_pkg::OP_Q_START: begin
          qopen <= 1'b1;
          if (!qopen) begin
            pieces <= '0;
            failed <= 1'b0;
            walk   <= ROOT;
          end
        end
        sac_pkg::OP_Q_TAKE: walk <= t_rd;
        sac_pkg::OP_Q_ROOT: begin
          if (pieces != {CW{1'b1}}) begin
            pieces <= pieces + 1'b1;
          end
        end
        sac_pkg::OP_Q_FAIL: begin
          failed <= 1'b1;
          walk   <= ROOT;
        end
        sac_pkg::OP_Q_OUT: begin
          qopen <= 1'b0;
          walk  <= ROOT;
        end
        default: qopen <= qopen;
      endcase
    end
  end

  // build registers and captured request
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      sym    <= in_sym;
      sym_ok <= status.in_sym_ok;
      last   <= in_last;
    end
    case (ctrl.op)
      sac_pkg::OP_APPEND_START: begin
        p  <= newest;
        np <= sc_inc;
        k  <= '0;
      end
      sac_pkg::OP_ROW_CLR: k <= k + 1'b1;
      sac_pkg::OP_W1_SET, sac_pkg::OP_W2_SET: p <= l_rd;
      sac_pkg::OP_W1_HIT: begin
        q     <= t_rd;
        len_p <= n_rd;
      end
      sac_pkg::OP_CLONE: begin
        nq <= sc_inc;
        k  <= '0;
      end
      sac_pkg::OP_CPY_WR: k <= k + 1'b1;
      default: k <= k;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == sac_pkg::OP_Q_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == sac_pkg::OP_Q_OUT) begin
      out_data <= {full, failed, failed ? {CW{1'b0}} : pieces};
    end
  end

endmodule

[sv/suffix_automaton_cover_counter.sv]
// -----------------------------------------------------------------------------
// suffix_automaton_cover_counter - greedy substring cover counter
// Builds a suffix automaton of a reference string and counts the fewest
// reference substrings that make up each streamed query string.
//
//  channel  dir  tdata                          tuser            tlast
//  s_axis   in   [4:0] symbol                   [1:0] command    last_of_query
//  m_axis   out  [15:0] pieces, [16] no_cover,  -                -
//                [17] reference_full
//
// one request at a time; a clear completes without leaving the idle state, a query symbol
// takes up to two transition lookups, and an append clears the new row entry by entry,
// walks the suffix links, and when a clone is made copies the row into it
// synchronous reset; the root row reads empty through per-symbol valid bits
// a result waits in the output register; a further last symbol stalls there
// -----------------------------------------------------------------------------
module suffix_automaton_cover_counter #(
  parameter int MAX_REF_LEN = sac_pkg::MAX_REF_LEN_DEF,
  parameter int MAX_STATES  = sac_pkg::MAX_STATES_DEF,
  parameter int ALPHABET    = sac_pkg::ALPHABET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // symbol[4:0], zero[7:5]
  input  logic [1:0]  s_tuser,   // command[1:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // pieces[15:0], no_cover[16], reference_full[17]
);

  sac_pkg::ctrl_t   ctrl;
  sac_pkg::status_t status;
  logic [17:0]      out_data;

  sac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  sac_dp #(
    .MAX_REF_LEN (MAX_REF_LEN),
    .MAX_STATES  (MAX_STATES),
    .ALPHABET    (ALPHABET)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_command (s_tuser),
    .in_symbol  (s_tdata[4:0]),
    .in_last    (s_tlast),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  assign m_tdata = {6'b0, out_data};

endmodule

[sv/sac_chk.sv]
// -----------------------------------------------------------------------------
// sac_chk - port checker for the suffix automaton cover counter
// Watches the request and result ports for stalls, reset, result format and clear completion.
// -----------------------------------------------------------------------------
module sac_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // an uncoverable query reports no pieces
  a_nocover: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
    else $error("piece count with no cover");

  // a clear request leaves the block ready in the next cycle
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == sac_pkg::CMD_CLEAR |=> s_tready)
    else $error("clear request did not finish in one cycle");

endmodule

bind suffix_automaton_cover_counter sac_chk u_sac_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
